@@ sv/cse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cse_pkg
// shared widths, status codes and polynomial coefficients
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int X_BITS   = 24;
    localparam int ACC_W    = 52;
    localparam int MAG_W    = ACC_W - 1;
    localparam int NUM_COEF = 11;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RATIO = 2'd1,
        ST_ZERO  = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    // coefficients with 32 fraction bits, rounded to nearest
    function automatic logic signed [ACC_W-1:0] coef(input logic [3:0] idx);
        logic signed [ACC_W-1:0] c;
        begin
            case (idx)
                4'd0:    c = -52'sd1875741067;
                4'd1:    c = 52'sd180781616;
                4'd2:    c = -52'sd7970170811;
                4'd3:    c = 52'sd109332687487;
                4'd4:    c = -52'sd864009981002;
                4'd5:    c = 52'sd3940666853818;
                4'd6:    c = -52'sd10999969590804;
                4'd7:    c = 52'sd19064114286428;
                4'd8:    c = -52'sd20025413866619;
                4'd9:    c = 52'sd11680206511145;
                4'd10:   c = -52'sd2907289132466;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

@@ sv/cse_ratio_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cse_ratio_div
// range checks and a one-bit-per-stage divider forming x = pos / radius (Q0.24)
// ----------------------------------------------------------------------------
module cse_ratio_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_vld,
    input  wire logic [31:0]                  pos,
    input  wire logic [31:0]                  rad,
    output logic                              out_vld,
    output logic [cse_pkg::X_BITS-1:0]        x,
    output logic [31:0]                       out_rad,
    output cse_pkg::status_t                  out_code
);

    localparam int N = cse_pkg::X_BITS;

    logic                 vld_reg  [0:N];
    logic [32:0]          rem_reg  [0:N];
    logic [N-1:0]         q_reg    [0:N];
    logic [31:0]          rad_reg  [0:N];
    cse_pkg::status_t     code_reg [0:N];

    logic [35:0]          pos10;
    logic [35:0]          rad9;
    cse_pkg::status_t     code_next;

    // exact ratio test and zero radius test
    always_comb
    begin
        pos10 = {4'd0, pos} * 36'd10;
        rad9  = {4'd0, rad} * 36'd9;
        if (rad == 32'd0)
            code_next = cse_pkg::ST_ZERO;
        else if (pos10 > rad9)
            code_next = cse_pkg::ST_RATIO;
        else
            code_next = cse_pkg::ST_OK;
    end

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {1'b0, pos};
            q_reg[0]    <= '0;
            rad_reg[0]  <= rad;
            code_reg[0] <= code_next;
        end
    end

    // one quotient bit per stage
    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [33:0] rem_sh;
        logic [33:0] rem_next;
        logic        bit_next;

        always_comb
        begin
            rem_sh = {rem_reg[i], 1'b0};
            if (rem_sh >= {2'b00, rad_reg[i]})
            begin
                rem_next = rem_sh - {2'b00, rad_reg[i]};
                bit_next = 1'b1;
            end
            else
            begin
                rem_next = rem_sh;
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next[32:0];
                q_reg[i+1]    <= {q_reg[i][N-2:0], bit_next};
                rad_reg[i+1]  <= rad_reg[i];
                code_reg[i+1] <= code_reg[i];
            end
        end
    end

    assign out_vld  = vld_reg[N];
    assign x        = q_reg[N];
    assign out_rad  = rad_reg[N];
    assign out_code = code_reg[N];

endmodule
`default_nettype wire

@@ sv/cse_horner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cse_horner
// horner chain, two stages per coefficient after the leading one: split multiply, then round and add
// ----------------------------------------------------------------------------
module cse_horner
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_vld,
    input  wire logic [cse_pkg::X_BITS-1:0]        x,
    input  wire logic [31:0]                       rad,
    input  wire cse_pkg::status_t                  code,
    output logic                                   out_vld,
    output logic signed [cse_pkg::ACC_W-1:0]       acc,
    output logic [31:0]                            out_rad,
    output cse_pkg::status_t                       out_code
);

    localparam int XB    = cse_pkg::X_BITS;
    localparam int AW    = cse_pkg::ACC_W;
    localparam int MW    = cse_pkg::MAG_W;
    localparam int HW    = MW - XB;
    localparam int STEPS = cse_pkg::NUM_COEF - 1;

    // accumulator stage j holds the value before step j
    logic                 avld_reg  [0:STEPS];
    logic signed [AW-1:0] acc_reg   [0:STEPS];
    logic [XB-1:0]        ax_reg    [0:STEPS];
    logic [31:0]          arad_reg  [0:STEPS];
    cse_pkg::status_t     acode_reg [0:STEPS];

    // product stage of step j
    logic                 pvld_reg  [0:STEPS-1];
    logic                 pneg_reg  [0:STEPS-1];
    logic [MW-1:0]        phi_reg   [0:STEPS-1];
    logic [HW+XB-2:0]     plo_reg   [0:STEPS-1];
    logic [XB-1:0]        px_reg    [0:STEPS-1];
    logic [31:0]          prad_reg  [0:STEPS-1];
    cse_pkg::status_t     pcode_reg [0:STEPS-1];

    // entry: leading coefficient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            avld_reg[0] <= 1'b0;
        else if (en)
            avld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0]   <= cse_pkg::coef(4'(STEPS));
            ax_reg[0]    <= x;
            arad_reg[0]  <= rad;
            acode_reg[0] <= code;
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        logic          neg;
        logic [AW-1:0] mag;
        logic [MW-1:0] hi_prod;
        logic [HW+XB-2:0] lo_sum;
        logic [MW-1:0] p;
        logic signed [AW-1:0] acc_next;

        // partial products of |acc| * x
        always_comb
        begin
            neg     = acc_reg[j][AW-1];
            mag     = neg ? (AW'(0) - AW'(acc_reg[j])) : AW'(acc_reg[j]);
            hi_prod = MW'(mag[MW-1:XB] * ax_reg[j]);
            lo_sum  = (HW+XB-1)'(mag[XB-1:0] * ax_reg[j])
                      + (HW+XB-1)'(1 << (XB - 1));
        end

        // rounded product, sign restored, next coefficient added
        always_comb
        begin
            p        = phi_reg[j] + MW'(plo_reg[j] >> XB);
            acc_next = (pneg_reg[j] ? -$signed({1'b0, p}) : $signed({1'b0, p}))
                       + cse_pkg::coef(4'(STEPS - 1 - j));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pvld_reg[j]   <= 1'b0;
                avld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                pvld_reg[j]   <= avld_reg[j];
                avld_reg[j+1] <= pvld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pneg_reg[j]    <= neg;
                phi_reg[j]     <= hi_prod;
                plo_reg[j]     <= lo_sum;
                px_reg[j]      <= ax_reg[j];
                prad_reg[j]    <= arad_reg[j];
                pcode_reg[j]   <= acode_reg[j];
                acc_reg[j+1]   <= acc_next;
                ax_reg[j+1]    <= px_reg[j];
                arad_reg[j+1]  <= prad_reg[j];
                acode_reg[j+1] <= pcode_reg[j];
            end
        end
    end

    assign out_vld  = avld_reg[STEPS];
    assign acc      = acc_reg[STEPS];
    assign out_rad  = arad_reg[STEPS];
    assign out_code = acode_reg[STEPS];

endmodule
`default_nettype wire

@@ sv/cse_energy_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cse_energy_div
// one-bit-per-stage divider of |acc| by the radius, keeping the remainder
// ----------------------------------------------------------------------------
module cse_energy_div
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_vld,
    input  wire logic signed [cse_pkg::ACC_W-1:0]  acc,
    input  wire logic [31:0]                       rad,
    input  wire cse_pkg::status_t                  code,
    output logic                                   out_vld,
    output logic [cse_pkg::MAG_W-1:0]              quo,
    output logic [32:0]                            rem,
    output logic                                   neg,
    output logic [31:0]                            out_rad,
    output cse_pkg::status_t                       out_code
);

    localparam int AW = cse_pkg::ACC_W;
    localparam int N  = cse_pkg::MAG_W;

    logic             vld_reg  [0:N];
    logic [32:0]      rem_reg  [0:N];
    logic [N-1:0]     dq_reg   [0:N];
    logic             neg_reg  [0:N];
    logic [31:0]      rad_reg  [0:N];
    cse_pkg::status_t code_reg [0:N];

    logic [AW-1:0]    mag;

    assign mag = acc[AW-1] ? (AW'(0) - AW'(acc)) : AW'(acc);

    // entry: magnitude and sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            dq_reg[0]   <= mag[N-1:0];
            neg_reg[0]  <= acc[AW-1];
            rad_reg[0]  <= rad;
            code_reg[0] <= code;
        end
    end

    // dividend bits shift out at the top, quotient bits in at the bottom
    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [33:0] rem_sh;
        logic [33:0] rem_next;
        logic        bit_next;

        always_comb
        begin
            rem_sh = {rem_reg[i], dq_reg[i][N-1]};
            if (rem_sh >= {2'b00, rad_reg[i]})
            begin
                rem_next = rem_sh - {2'b00, rad_reg[i]};
                bit_next = 1'b1;
            end
            else
            begin
                rem_next = rem_sh;
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next[32:0];
                dq_reg[i+1]   <= {dq_reg[i][N-2:0], bit_next};
                neg_reg[i+1]  <= neg_reg[i];
                rad_reg[i+1]  <= rad_reg[i];
                code_reg[i+1] <= code_reg[i];
            end
        end
    end

    assign out_vld  = vld_reg[N];
    assign quo      = dq_reg[N];
    assign rem      = rem_reg[N];
    assign neg      = neg_reg[N];
    assign out_rad  = rad_reg[N];
    assign out_code = code_reg[N];

endmodule
`default_nettype wire

@@ sv/cylinder_self_energy_poly.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cylinder_self_energy_poly
// energy = p(pos / radius) / radius in Q16.16, fully pipelined
// ----------------------------------------------------------------------------
// One item enters and one result leaves per clock while no result is held
// at the output. An item passes one check stage and 24 stages of the ratio
// divider, 21 Horner stages (entry, then two per further coefficient), 52
// energy divider stages (entry, then one per quotient bit) and the output
// register. The whole pipeline halts while a result waits at the output, so
// nothing is lost; a zero radius or a ratio above 0.9 yields zero energy
// with an error status, and overflow saturates with status 3.
module cylinder_self_energy_poly
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [31:0]  radial_pos,
    input  wire logic [31:0]  cyl_radius,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       energy,
    output logic [1:0]        status
);

    localparam int MW = cse_pkg::MAG_W;

    logic                           en;
    logic                           r_vld;
    logic [cse_pkg::X_BITS-1:0]     r_x;
    logic [31:0]                    r_rad;
    cse_pkg::status_t               r_code;
    logic                           h_vld;
    logic signed [cse_pkg::ACC_W-1:0] h_acc;
    logic [31:0]                    h_rad;
    cse_pkg::status_t               h_code;
    logic                           d_vld;
    logic [MW-1:0]                  d_quo;
    logic [32:0]                    d_rem;
    logic                           d_neg;
    logic [31:0]                    d_rad;
    cse_pkg::status_t               d_code;

    logic                           out_valid_reg;
    logic [31:0]                    energy_reg;
    logic [1:0]                     status_reg;
    logic [31:0]                    energy_next;
    logic [1:0]                     status_next;

    // whole pipeline advances unless a result is held at the output
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    cse_ratio_div u_ratio
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .pos      (radial_pos),
        .rad      (cyl_radius),
        .out_vld  (r_vld),
        .x        (r_x),
        .out_rad  (r_rad),
        .out_code (r_code)
    );

    cse_horner u_horner
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (r_vld),
        .x        (r_x),
        .rad      (r_rad),
        .code     (r_code),
        .out_vld  (h_vld),
        .acc      (h_acc),
        .out_rad  (h_rad),
        .out_code (h_code)
    );

    cse_energy_div u_ediv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (h_vld),
        .acc      (h_acc),
        .rad      (h_rad),
        .code     (h_code),
        .out_vld  (d_vld),
        .quo      (d_quo),
        .rem      (d_rem),
        .neg      (d_neg),
        .out_rad  (d_rad),
        .out_code (d_code)
    );

    // rounding, saturation and sign; error items get zero energy
    always_comb
    begin
        logic [MW-1:0] limit;
        logic [MW-1:0] qr;
        logic [31:0]   mag;
        logic          sat;
        limit = d_neg ? MW'(33'h1_0000_0000 >> 1) : MW'(32'h7FFF_FFFF);
        qr    = d_quo + MW'(({d_rem, 1'b0} >= {2'b00, d_rad}) ? 1 : 0);
        sat   = (d_quo > limit) || (qr > limit);
        mag   = sat ? limit[31:0] : qr[31:0];
        if (d_code != cse_pkg::ST_OK)
        begin
            energy_next = '0;
            status_next = d_code;
        end
        else
        begin
            energy_next = d_neg ? (32'd0 - mag) : mag;
            status_next = sat ? cse_pkg::ST_SAT : cse_pkg::ST_OK;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            energy_reg <= energy_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign energy    = energy_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // error items carry zero energy
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cse_pkg::ST_RATIO || status == cse_pkg::ST_ZERO)
        |-> energy == 32'd0)
        else $error("error item with nonzero energy");

    // saturated items sit at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cse_pkg::ST_SAT
        |-> (energy == 32'h7FFF_FFFF || energy == 32'h8000_0000))
        else $error("saturated energy off the rail");

    // an empty output never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a held result freezes the pipeline
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(energy) && $stable(status))
        else $error("held result changed");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for cylinder_self_energy_poly
// ----------------------------------------------------------------------------
// A directed table covers zero radius, the 0.9 ratio limit and the field
// extremes. It is followed by random items, most of them with a ratio of
// 0.9 or less. Every result is compared in order with its expected value:
// typed in for directed error rows, else from a bit-exact energy predictor.
// The bench runs in four phases of sender idling and receiver stalling.
module testbench;

    typedef struct {
        logic [31:0]      energy;
        cse_pkg::status_t status;
    } energy_res_t;

    typedef struct {
        logic [31:0]      pos;
        logic [31:0]      rad;
        bit               typed;
        logic [31:0]      energy;
        cse_pkg::status_t status;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] radial_pos = '0;
    logic [31:0] cyl_radius = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [31:0] energy;
    logic [1:0]  status;

    energy_res_t pending_results[$];
    int          fail_count = 0;
    int          result_count = 0;
    int          sent_count = 0;
    int          sat_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    longint      coef_q32[cse_pkg::NUM_COEF];

    // polynomial constants times 10^7, lowest order first
    localparam longint COEF_DEC[cse_pkg::NUM_COEF] = '{
        -64'sd4367300, 64'sd420915, -64'sd18557000, 64'sd254560000,
        -64'sd2011680000, 64'sd9175080000, -64'sd25611300000,
        64'sd44387100000, -64'sd46625300000, 64'sd27195100000,
        -64'sd6769060000
    };

    cylinder_self_energy_poly dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .radial_pos (radial_pos),
        .cyl_radius (cyl_radius),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .energy     (energy),
        .status     (status)
    );

    always #5 clk = ~clk;

    // decimal constant to 32 fraction bits, ties away from zero
    function automatic longint dec_to_q32(input longint dec);
        bit          neg;
        bit [63:0]   mag;
        bit [63:0]   val;
        bit [63:0]   rem;
        begin
            neg = dec < 0;
            mag = neg ? -dec : dec;
            val = mag / 64'd10000000;
            rem = mag % 64'd10000000;
            for (int i = 0; i < 32; i++)
            begin
                rem = rem << 1;
                val = val << 1;
                if (rem >= 64'd10000000)
                begin
                    rem = rem - 64'd10000000;
                    val[0] = 1'b1;
                end
            end
            if (2 * rem >= 64'd10000000)
                val = val + 1;
            return neg ? -longint'(val) : longint'(val);
        end
    endfunction

    // acc * x / 2^24, magnitude rounded half up
    function automatic longint scale_by_ratio(input longint acc, input bit [63:0] x);
        bit        neg;
        bit [63:0] m;
        bit [63:0] p;
        begin
            neg = acc < 0;
            m = neg ? -acc : acc;
            p = (m >> 24) * x + ((m[23:0] * x + 64'h800000) >> 24);
            return neg ? -longint'(p) : longint'(p);
        end
    endfunction

    function automatic energy_res_t predict_energy(input logic [31:0] pos,
                                                   input logic [31:0] rad);
        energy_res_t r;
        bit [63:0]   x;
        bit [63:0]   m;
        bit [63:0]   q;
        bit [63:0]   rem;
        bit [63:0]   limit;
        longint      acc;
        bit          neg;
        begin
            r.energy = '0;
            if (rad == 0)
            begin
                r.status = cse_pkg::ST_ZERO;
                return r;
            end
            if (64'd10 * pos > 64'd9 * rad)
            begin
                r.status = cse_pkg::ST_RATIO;
                return r;
            end
            x = (64'(pos) << 24) / rad;
            acc = coef_q32[cse_pkg::NUM_COEF-1];
            for (int k = cse_pkg::NUM_COEF - 2; k >= 0; k--)
                acc = scale_by_ratio(acc, x) + coef_q32[k];
            neg = acc < 0;
            m = neg ? -acc : acc;
            limit = neg ? 64'h80000000 : 64'h7FFFFFFF;
            q = m / rad;
            rem = m % rad;
            if (q <= limit && 2 * rem >= rad)
                q = q + 1;
            if (q > limit)
            begin
                r.status = cse_pkg::ST_SAT;
                q = limit;
            end
            else
                r.status = cse_pkg::ST_OK;
            r.energy = neg ? -q[31:0] : q[31:0];
            return r;
        end
    endfunction

    // present one item, hold it until taken, then idle at random
    task automatic send_item(input logic [31:0] pos, input logic [31:0] rad,
                             input bit typed, input energy_res_t typed_res);
        begin
            in_valid <= 1'b1;
            radial_pos <= pos;
            cyl_radius <= rad;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            pending_results.push_back(typed ? typed_res : predict_energy(pos, rad));
            sent_count++;
            if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < idle_pct)
                    @(posedge clk);
            end
        end
    endtask

    task automatic send_random;
        logic [31:0] rad;
        logic [31:0] pos;
        energy_res_t none;
        int          pick;
        begin
            none.energy = '0;
            none.status = cse_pkg::ST_OK;
            pick = $urandom_range(99);
            rad = (pick < 30) ? 32'($urandom_range(1, 255)) : $urandom;
            if (pick < 85)
                pos = 32'((64'(rad) * $urandom_range(0, 900)) / 1000);
            else if (pick < 97)
                pos = $urandom;
            else
            begin
                pos = $urandom;
                rad = '0;
            end
            send_item(pos, rad, 1'b0, none);
        end
    endtask

    // receiver: random stalls and in-order compare
    always @(posedge clk)
    begin
        energy_res_t want;
        if (out_valid && out_ready && rst_n)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: result with nothing expected: energy %h status %0d",
                         $time, energy, status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status == cse_pkg::ST_SAT)
                    sat_count++;
                if (energy !== want.energy)
                begin
                    fail_count++;
                    $display("%0t: energy expected %h actual %h", $time,
                             want.energy, energy);
                end
                if (status !== want.status)
                begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, status);
                end
            end
        end
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        stim_row_t   rows[$];
        energy_res_t typed_res;
        int          phase_idle[4];
        int          phase_stall[4];

        for (int k = 0; k < cse_pkg::NUM_COEF; k++)
            coef_q32[k] = dec_to_q32(COEF_DEC[k]);

        // directed rows: error codes typed in, others predicted
        rows = '{
            '{32'h0, 32'h0, 1'b1, 32'h0, cse_pkg::ST_ZERO},
            '{32'hFFFFFFFF, 32'h0, 1'b1, 32'h0, cse_pkg::ST_ZERO},
            '{32'h1, 32'h1, 1'b1, 32'h0, cse_pkg::ST_RATIO},
            '{32'd10, 32'd11, 1'b1, 32'h0, cse_pkg::ST_RATIO},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h0, cse_pkg::ST_RATIO},
            '{32'hFFFFFFFF, 32'h1, 1'b1, 32'h0, cse_pkg::ST_RATIO},
            '{32'd9, 32'd10, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'd3865470565, 32'hFFFFFFFF, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h0, 32'h1, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h0, 32'hFFFFFFFF, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h0, 32'h10000, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h8000, 32'h10000, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h1, 32'h2, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h1, 32'h3, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h7, 32'h8, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h3, 32'h4, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h2, 32'h5, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h70000000, 32'h80000000, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'hAAAAAAAA, 32'hFFFFFFFF, 1'b0, 32'h0, cse_pkg::ST_OK},
            '{32'h55555555, 32'h5FFFFFFF, 1'b0, 32'h0, cse_pkg::ST_OK}
        };
        phase_idle  = '{0, 80, 0, 7};
        phase_stall = '{0, 0, 80, 7};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            typed_res.energy = rows[i].energy;
            typed_res.status = rows[i].status;
            send_item(rows[i].pos, rows[i].rad, rows[i].typed, typed_res);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            repeat (160)
                send_random();
        end
        in_valid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d items, checked %0d results, %0d saturated",
                 sent_count, result_count, sat_count);
        $display("phases: free flow, sender idle, receiver stall, light mix");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/cse_pkg.sv
sv/cse_ratio_div.sv
sv/cse_horner.sv
sv/cse_energy_div.sv
sv/cylinder_self_energy_poly.sv
tb/testbench.sv
